// ===== design/npp_pkg.sv =====
package npp_pkg;

  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TA,
    S_TB,
    S_LA,
    S_LB,
    S_DEC,
    S_NX0,
    S_NX1,
    S_NY0,
    S_NY1,
    S_NYF,
    S_DIV,
    S_DIST,
    S_DIST2,
    S_CMP,
    S_EMIT
  } npp_state_t;

endpackage

// ===== design/npp_mul.sv =====
module npp_mul
  import npp_pkg::*;
#(
  parameter int MW = COORD_BITS_DEF + 2
) (
  input  logic                   clk,
  input  logic signed [MW-1:0]   a,
  input  logic signed [MW-1:0]   b,
  output logic signed [2*MW-1:0] p
);

  logic signed [2*MW-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

// ===== design/npp_div.sv =====
module npp_div
  import npp_pkg::*;
#(
  parameter int CW = COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [3*CW+1:0]     num_x,
  input  logic [3*CW+1:0]     num_y,
  input  logic [2*CW+1:0]     den,
  output logic                done,
  output logic [CW:0]         q_x,
  output logic [CW:0]         q_y
);

  localparam int QW   = CW + 1;
  localparam int NW   = 3 * CW + 2;
  localparam int CNTW = $clog2(QW);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]   rem_x_r, rem_x_nxt;
  logic [NW-1:0]   rem_y_r, rem_y_nxt;
  logic [NW-1:0]   dsh_r, dsh_nxt;
  logic [QW-1:0]   q_x_r, q_x_nxt;
  logic [QW-1:0]   q_y_r, q_y_nxt;
  logic            ge_x, ge_y;

  // Both quotients are produced together; the two lanes share the shifted divisor.
  assign ge_x = (rem_x_r >= dsh_r);
  assign ge_y = (rem_y_r >= dsh_r);

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    rem_x_nxt = rem_x_r;
    rem_y_nxt = rem_y_r;
    dsh_nxt   = dsh_r;
    q_x_nxt   = q_x_r;
    q_y_nxt   = q_y_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = CNTW'(QW - 1);
      rem_x_nxt = num_x;
      rem_y_nxt = num_y;
      dsh_nxt   = {den, {CW{1'b0}}};
    end else if (busy_r) begin
      if (ge_x) begin
        rem_x_nxt = rem_x_r - dsh_r;
      end
      if (ge_y) begin
        rem_y_nxt = rem_y_r - dsh_r;
      end
      q_x_nxt = {q_x_r[QW-2:0], ge_x};
      q_y_nxt = {q_y_r[QW-2:0], ge_y};
      dsh_nxt = dsh_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r   <= cnt_nxt;
    rem_x_r <= rem_x_nxt;
    rem_y_r <= rem_y_nxt;
    dsh_r   <= dsh_nxt;
    q_x_r   <= q_x_nxt;
    q_y_r   <= q_y_nxt;
  end

  assign done = done_r;
  assign q_x  = q_x_r;
  assign q_y  = q_y_r;

endmodule

// ===== design/nearest_point_on_polyline_top.sv =====
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    robot_x, robot_y, vertex_x, vertex_y, last_vertex
// out      output     out_valid / out_stall  nearest_x/y, segment_end_x/y, min_distance_sq,
//                                            valid_res
//
// The first vertex of a path is stored with the robot position; when it is also the last
// one, the result step follows. Every later vertex skips the division when the projection
// falls on an end point or the segment is vertical, and needs it otherwise; the shared
// multiplier and the restoring divider (COORD_BITS + 1 steps) do that work.
// A later vertex that ends the path is followed by the result step.
// in_stall is high while a vertex is being worked on. Reset is synchronous.
// A result waits in the output register; only a path end that finds it still
// stalled holds the block until it is taken.
module nearest_point_on_polyline_top
  import npp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [COORD_BITS-1:0]   in_robot_x,
  input  logic [COORD_BITS-1:0]   in_robot_y,
  input  logic [COORD_BITS-1:0]   in_vertex_x,
  input  logic [COORD_BITS-1:0]   in_vertex_y,
  input  logic                    in_last_vertex,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [COORD_BITS-1:0]   out_nearest_x,
  output logic [COORD_BITS-1:0]   out_nearest_y,
  output logic [COORD_BITS-1:0]   out_segment_end_x,
  output logic [COORD_BITS-1:0]   out_segment_end_y,
  output logic [2*COORD_BITS:0]   out_min_distance_sq,
  output logic                    out_valid_res
);

  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;
  localparam int MW  = CW + 2;
  localparam int PW  = 2 * MW;
  localparam int TW  = 2 * CW + 2;
  localparam int LW  = 2 * CW + 2;
  localparam int NW  = 3 * CW + 2;
  localparam int DSW = 2 * CW + 1;

  npp_state_t state_r, state_nxt;

  logic                 have_prev_r, have_prev_nxt;
  logic                 found_r, found_nxt;
  logic                 last_r, last_nxt;
  logic signed [CW-1:0] prev_x_r, prev_x_nxt;
  logic signed [CW-1:0] prev_y_r, prev_y_nxt;
  logic signed [CW-1:0] rob_x_r, rob_x_nxt;
  logic signed [CW-1:0] rob_y_r, rob_y_nxt;
  logic signed [CW-1:0] nx_r, nx_nxt;
  logic signed [CW-1:0] ny_r, ny_nxt;
  logic [DW-1:0]        dx_r, dx_nxt;
  logic [DW-1:0]        dy_r, dy_nxt;
  logic [DW-1:0]        rpx_r, rpx_nxt;
  logic [DW-1:0]        rpy_r, rpy_nxt;
  logic [PW-1:0]        acc_r, acc_nxt;
  logic [TW-1:0]        t_r, t_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic [NW-1:0]        numx_r, numx_nxt;
  logic [NW-1:0]        numy_r, numy_nxt;
  logic signed [CW-1:0] cand_x_r, cand_x_nxt;
  logic signed [CW-1:0] cand_y_r, cand_y_nxt;
  logic [DSW-1:0]       best_d_r, best_d_nxt;
  logic [CW-1:0]        best_px_r, best_px_nxt;
  logic [CW-1:0]        best_py_r, best_py_nxt;
  logic [CW-1:0]        best_ex_r, best_ex_nxt;
  logic [CW-1:0]        best_ey_r, best_ey_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CW-1:0]        out_nx_r, out_nx_nxt;
  logic [CW-1:0]        out_ny_r, out_ny_nxt;
  logic [CW-1:0]        out_ex_r, out_ex_nxt;
  logic [CW-1:0]        out_ey_r, out_ey_nxt;
  logic [DSW-1:0]       out_d_r, out_d_nxt;
  logic                 out_res_r, out_res_nxt;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic [PW-1:0]        acc_sum;
  logic [DW-1:0]        absdx, absdy;
  logic [NW-1:0]        lo_ext, hi_ext;
  logic [LW-1:0]        len_w;
  logic [DSW-1:0]       dist_w;
  logic [DW-1:0]        ex, ey;
  logic signed [CW-1:0] cy_lo, cy_hi, cy_clamp;
  logic [MW-1:0]        projx_full, projy_full;
  logic                 div_start, div_done;
  logic [CW:0]          div_qx, div_qy;
  logic [NW-1:0]        div_numy;
  logic                 accept;

  npp_mul #(.MW(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  npp_div #(.CW(CW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num_x (numx_r),
    .num_y (div_numy),
    .den   (len_r),
    .done  (div_done),
    .q_x   (div_qx),
    .q_y   (div_qy)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign acc_sum = acc_r + prod;
  assign len_w   = acc_sum[LW-1:0];
  assign dist_w  = acc_sum[DSW-1:0];
  assign absdx   = dx_r[DW-1] ? (~dx_r + 1'b1) : dx_r;
  assign absdy   = dy_r[DW-1] ? (~dy_r + 1'b1) : dy_r;

  // Partial products of |d| * T, with T split into a low and a high part.
  assign lo_ext   = {{(CW+1){1'b0}}, prod[2*CW:0]};
  assign hi_ext   = {prod[2*CW:0], {(CW+1){1'b0}}};
  assign div_numy = numy_r + hi_ext;

  assign ex = {cand_x_r[CW-1], cand_x_r} - {rob_x_r[CW-1], rob_x_r};
  assign ey = {cand_y_r[CW-1], cand_y_r} - {rob_y_r[CW-1], rob_y_r};

  assign cy_lo    = (prev_y_r < ny_r) ? prev_y_r : ny_r;
  assign cy_hi    = (prev_y_r < ny_r) ? ny_r : prev_y_r;
  assign cy_clamp = (rob_y_r < cy_lo) ? cy_lo : ((rob_y_r > cy_hi) ? cy_hi : rob_y_r);

  // The quotient is below |d|, so the projection stays inside the bounding box.
  assign projx_full = dx_r[DW-1]
                    ? ({{2{prev_x_r[CW-1]}}, prev_x_r} - {1'b0, div_qx})
                    : ({{2{prev_x_r[CW-1]}}, prev_x_r} + {1'b0, div_qx});
  assign projy_full = dy_r[DW-1]
                    ? ({{2{prev_y_r[CW-1]}}, prev_y_r} - {1'b0, div_qy})
                    : ({{2{prev_y_r[CW-1]}}, prev_y_r} + {1'b0, div_qy});

  always_comb begin
    state_nxt     = state_r;
    have_prev_nxt = have_prev_r;
    found_nxt     = found_r;
    last_nxt      = last_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    rob_x_nxt     = rob_x_r;
    rob_y_nxt     = rob_y_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    rpx_nxt       = rpx_r;
    rpy_nxt       = rpy_r;
    acc_nxt       = acc_r;
    t_nxt         = t_r;
    len_nxt       = len_r;
    numx_nxt      = numx_r;
    numy_nxt      = numy_r;
    cand_x_nxt    = cand_x_r;
    cand_y_nxt    = cand_y_r;
    best_d_nxt    = best_d_r;
    best_px_nxt   = best_px_r;
    best_py_nxt   = best_py_r;
    best_ex_nxt   = best_ex_r;
    best_ey_nxt   = best_ey_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nx_nxt    = out_nx_r;
    out_ny_nxt    = out_ny_r;
    out_ex_nxt    = out_ex_r;
    out_ey_nxt    = out_ey_r;
    out_d_nxt     = out_d_r;
    out_res_nxt   = out_res_r;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt = in_last_vertex;
          if (!have_prev_r) begin
            rob_x_nxt     = in_robot_x;
            rob_y_nxt     = in_robot_y;
            prev_x_nxt    = in_vertex_x;
            prev_y_nxt    = in_vertex_y;
            found_nxt     = 1'b0;
            have_prev_nxt = 1'b1;
            state_nxt     = in_last_vertex ? S_EMIT : S_IDLE;
          end else begin
            nx_nxt    = in_vertex_x;
            ny_nxt    = in_vertex_y;
            dx_nxt    = {in_vertex_x[CW-1], in_vertex_x} - {prev_x_r[CW-1], prev_x_r};
            dy_nxt    = {in_vertex_y[CW-1], in_vertex_y} - {prev_y_r[CW-1], prev_y_r};
            rpx_nxt   = {rob_x_r[CW-1], rob_x_r} - {prev_x_r[CW-1], prev_x_r};
            rpy_nxt   = {rob_y_r[CW-1], rob_y_r} - {prev_y_r[CW-1], prev_y_r};
            state_nxt = S_TA;
          end
        end
      end
      S_TA: begin
        mul_a     = {rpx_r[DW-1], rpx_r};
        mul_b     = {dx_r[DW-1], dx_r};
        state_nxt = S_TB;
      end
      S_TB: begin
        mul_a     = {rpy_r[DW-1], rpy_r};
        mul_b     = {dy_r[DW-1], dy_r};
        acc_nxt   = prod;
        state_nxt = S_LA;
      end
      S_LA: begin
        mul_a     = {dx_r[DW-1], dx_r};
        mul_b     = {dx_r[DW-1], dx_r};
        t_nxt     = acc_sum[TW-1:0];
        state_nxt = S_LB;
      end
      S_LB: begin
        mul_a     = {dy_r[DW-1], dy_r};
        mul_b     = {dy_r[DW-1], dy_r};
        acc_nxt   = prod;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        len_nxt = len_w;
        if (dx_r == '0) begin
          // Vertical segment: keep the vertex X and the robot Y, clamped to the segment.
          cand_x_nxt = prev_x_r;
          cand_y_nxt = cy_clamp;
          state_nxt  = S_DIST;
        end else if (t_r[TW-1] || (t_r == '0)) begin
          cand_x_nxt = prev_x_r;
          cand_y_nxt = prev_y_r;
          state_nxt  = S_DIST;
        end else if (t_r >= len_w) begin
          cand_x_nxt = nx_r;
          cand_y_nxt = ny_r;
          state_nxt  = S_DIST;
        end else begin
          state_nxt = S_NX0;
        end
      end
      S_NX0: begin
        mul_a     = {1'b0, absdx};
        mul_b     = {1'b0, t_r[CW:0]};
        state_nxt = S_NX1;
      end
      S_NX1: begin
        mul_a     = {1'b0, absdx};
        mul_b     = {2'b00, t_r[2*CW:CW+1]};
        numx_nxt  = lo_ext;
        state_nxt = S_NY0;
      end
      S_NY0: begin
        mul_a     = {1'b0, absdy};
        mul_b     = {1'b0, t_r[CW:0]};
        numx_nxt  = numx_r + hi_ext;
        state_nxt = S_NY1;
      end
      S_NY1: begin
        mul_a     = {1'b0, absdy};
        mul_b     = {2'b00, t_r[2*CW:CW+1]};
        numy_nxt  = lo_ext;
        state_nxt = S_NYF;
      end
      S_NYF: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          cand_x_nxt = projx_full[CW-1:0];
          cand_y_nxt = projy_full[CW-1:0];
          state_nxt  = S_DIST;
        end
      end
      S_DIST: begin
        mul_a     = {ex[DW-1], ex};
        mul_b     = {ex[DW-1], ex};
        state_nxt = S_DIST2;
      end
      S_DIST2: begin
        mul_a     = {ey[DW-1], ey};
        mul_b     = {ey[DW-1], ey};
        acc_nxt   = prod;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // A tie goes to the later segment.
        if (!found_r || (dist_w <= best_d_r)) begin
          best_d_nxt  = dist_w;
          best_px_nxt = cand_x_r;
          best_py_nxt = cand_y_r;
          best_ex_nxt = nx_r;
          best_ey_nxt = ny_r;
        end
        found_nxt  = 1'b1;
        prev_x_nxt = nx_r;
        prev_y_nxt = ny_r;
        state_nxt  = last_r ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = found_r;
          out_nx_nxt    = found_r ? best_px_r : '0;
          out_ny_nxt    = found_r ? best_py_r : '0;
          out_ex_nxt    = found_r ? best_ex_r : '0;
          out_ey_nxt    = found_r ? best_ey_r : '0;
          out_d_nxt     = found_r ? best_d_r : '0;
          have_prev_nxt = 1'b0;
          found_nxt     = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_prev_r <= have_prev_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r    <= last_nxt;
    prev_x_r  <= prev_x_nxt;
    prev_y_r  <= prev_y_nxt;
    rob_x_r   <= rob_x_nxt;
    rob_y_r   <= rob_y_nxt;
    nx_r      <= nx_nxt;
    ny_r      <= ny_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    rpx_r     <= rpx_nxt;
    rpy_r     <= rpy_nxt;
    acc_r     <= acc_nxt;
    t_r       <= t_nxt;
    len_r     <= len_nxt;
    numx_r    <= numx_nxt;
    numy_r    <= numy_nxt;
    cand_x_r  <= cand_x_nxt;
    cand_y_r  <= cand_y_nxt;
    best_d_r  <= best_d_nxt;
    best_px_r <= best_px_nxt;
    best_py_r <= best_py_nxt;
    best_ex_r <= best_ex_nxt;
    best_ey_r <= best_ey_nxt;
    out_nx_r  <= out_nx_nxt;
    out_ny_r  <= out_ny_nxt;
    out_ex_r  <= out_ex_nxt;
    out_ey_r  <= out_ey_nxt;
    out_d_r   <= out_d_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_nearest_x       = out_nx_r;
  assign out_nearest_y       = out_ny_r;
  assign out_segment_end_x   = out_ex_r;
  assign out_segment_end_y   = out_ey_r;
  assign out_min_distance_sq = out_d_r;
  assign out_valid_res       = out_res_r;

endmodule

// ===== design/npp_chk.sv =====
module npp_chk
  import npp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] out_nearest_x,
  input logic [COORD_BITS-1:0] out_nearest_y,
  input logic [COORD_BITS-1:0] out_segment_end_x,
  input logic [COORD_BITS-1:0] out_segment_end_y,
  input logic [2*COORD_BITS:0] out_min_distance_sq,
  input logic                  out_valid_res
);

  // After reset the block is empty and ready for a new path.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("block not empty after reset");

  // A path with a single vertex reports all fields as zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |->
      (out_nearest_x == '0 && out_nearest_y == '0 && out_segment_end_x == '0 &&
       out_segment_end_y == '0 && out_min_distance_sq == '0))
    else $error("invalid result carries nonzero fields");

  // A new result is loaded only from the path-end step, when no vertex is taken.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a path end");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_nearest_x) && $stable(out_nearest_y) &&
       $stable(out_min_distance_sq) && $stable(out_valid_res)))
    else $error("stalled result changed");

  // A stalled input transaction stays on offer until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> in_valid)
    else $error("input transaction withdrawn while stalled");

endmodule

bind nearest_point_on_polyline_top npp_chk #(.COORD_BITS(COORD_BITS)) u_npp_chk (.*);
